@@ hw/rtl/stick_radial_dead_zone_macros.svh @@
// Assertion macros shared by the stick conditioner checks
`ifndef STICK_RADIAL_DEAD_ZONE_MACROS_SVH
`define STICK_RADIAL_DEAD_ZONE_MACROS_SVH

// condition holds at every edge out of reset
`define SRDZ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent follows antecedent in the next cycle
`define SRDZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/srdz_pkg.sv @@
// Shared constants and types for the stick conditioner
package srdz_pkg;
	localparam int AXIS_FULL_SCALE_DEF = 32767;
	localparam int AXIS_W  = 16;
	localparam int DZ_W    = 15;
	localparam int ROOT_W  = 24;
	localparam int RAD_W   = 48;
	localparam int SREM_W  = 28;
	localparam int Q_W     = 16;
	localparam int DEN_W   = 24;
	localparam int DREM_W  = 25;
	localparam int LANES   = 3;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic                     act;
	} sqrt_side_t;

	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic act;
	} div_side_t;
endpackage

@@ hw/rtl/stick_radial_dead_zone.sv @@
// Radial dead zone stick conditioner: picks one stick, returns unit direction and level.
// Takes one request per cycle while the output is not stalled and gives one result per
// request, through a squaring stage, a compare stage, a chain of 24 square root cells
// (one root bit each), a divider setup stage, a chain of 16 divider cells (one
// quotient bit each, three lanes side by side) and the output register. The whole
// pipe holds while a result waits at the output, so s_tready follows the output side.
module stick_radial_dead_zone #(
	parameter int AXIS_FULL_SCALE = srdz_pkg::AXIS_FULL_SCALE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        dead_zone_wr,
	input  logic [14:0] dead_zone_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // left_x, left_y, right_x, right_y
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // dir_x, dir_y, level, active, zero fill
);
	localparam int SQ_N  = srdz_pkg::ROOT_W;
	localparam int DV_N  = srdz_pkg::Q_W;
	localparam logic [srdz_pkg::DZ_W-1:0] FS = srdz_pkg::DZ_W'(AXIS_FULL_SCALE);

	logic                        adv;
	logic [srdz_pkg::DZ_W-1:0]   dz_q;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= '0;
		end else if (dead_zone_wr) begin
			dz_q <= (dead_zone_wdata > FS - 1'b1) ? FS - 1'b1 : dead_zone_wdata;
		end
	end

	// square the chosen axes
	logic signed [15:0] sel_x, sel_y;
	logic signed [31:0] px, py;
	logic               vld_s1;
	logic [30:0]        xsq_s1, ysq_s1;
	srdz_pkg::sqrt_side_t side_s1;

	assign sel_x = s_tuser ? s_tdata[47:32] : s_tdata[15:0];
	assign sel_y = s_tuser ? s_tdata[63:48] : s_tdata[31:16];
	assign px    = sel_x * sel_x;
	assign py    = sel_y * sel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xsq_s1       <= px[30:0];
			ysq_s1       <= py[30:0];
			side_s1.x    <= sel_x;
			side_s1.y    <= sel_y;
			side_s1.act  <= 1'b0;
		end
	end

	// sum and dead zone test
	logic [31:0] sum;
	logic [29:0] dzsq;
	logic        vld_s2;
	logic [srdz_pkg::RAD_W-1:0] rad_s2;
	srdz_pkg::sqrt_side_t side_s2;

	assign sum  = {1'b0, xsq_s1} + {1'b0, ysq_s1};
	assign dzsq = dz_q * dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s2      <= {sum, 16'h0000};
			side_s2.x   <= side_s1.x;
			side_s2.y   <= side_s1.y;
			side_s2.act <= sum > {2'b00, dzsq};
		end
	end

	// square root chain
	logic                         sq_vld  [0:SQ_N];
	logic [srdz_pkg::SREM_W-1:0]  sq_rem  [0:SQ_N];
	logic [srdz_pkg::ROOT_W-1:0]  sq_root [0:SQ_N];
	logic [srdz_pkg::RAD_W-1:0]   sq_rad  [0:SQ_N];
	srdz_pkg::sqrt_side_t         sq_side [0:SQ_N];

	assign sq_vld[0]  = vld_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = rad_s2;
	assign sq_side[0] = side_s2;

	for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
		srdz_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (sq_vld[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.rad_i  (sq_rad[i]),
			.side_i (sq_side[i]),
			.vld_q  (sq_vld[i+1]),
			.rem_q  (sq_rem[i+1]),
			.root_q (sq_root[i+1]),
			.rad_q  (sq_rad[i+1]),
			.side_q (sq_side[i+1])
		);
	end

	// divider setup
	logic [15:0] ax, ay;
	logic [22:0] full8, mclip, lnum;
	logic [23:0] mag;
	logic        vld_s3;
	logic [srdz_pkg::LANES-1:0][srdz_pkg::DREM_W-1:0] rem_s3;
	logic [srdz_pkg::LANES-1:0][srdz_pkg::DEN_W-1:0]  den_s3;
	logic [srdz_pkg::LANES-1:0][srdz_pkg::Q_W-1:0]    num_s3;
	srdz_pkg::div_side_t side_s3;

	assign mag   = sq_root[SQ_N];
	assign ax    = sq_side[SQ_N].x[15] ? 16'(-sq_side[SQ_N].x) : 16'(sq_side[SQ_N].x);
	assign ay    = sq_side[SQ_N].y[15] ? 16'(-sq_side[SQ_N].y) : 16'(sq_side[SQ_N].y);
	assign full8 = {FS, 8'h00};
	assign mclip = (mag > {1'b0, full8}) ? full8 : mag[22:0];
	assign lnum  = mclip - {dz_q, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sq_vld[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s3[0]     <= {2'b00, ax, 7'h00};
			rem_s3[1]     <= {2'b00, ay, 7'h00};
			rem_s3[2]     <= {3'b000, lnum[22:1]};
			num_s3[0]     <= '0;
			num_s3[1]     <= '0;
			num_s3[2]     <= {lnum[0], 15'h0000};
			den_s3[0]     <= mag;
			den_s3[1]     <= mag;
			den_s3[2]     <= {1'b0, FS - dz_q, 8'h00};
			side_s3.x_neg <= sq_side[SQ_N].x[15];
			side_s3.y_neg <= sq_side[SQ_N].y[15];
			side_s3.act   <= sq_side[SQ_N].act;
		end
	end

	// divider chain
	logic                                             dv_vld  [0:DV_N];
	logic [srdz_pkg::LANES-1:0][srdz_pkg::DREM_W-1:0] dv_rem  [0:DV_N];
	logic [srdz_pkg::LANES-1:0][srdz_pkg::DEN_W-1:0]  dv_den  [0:DV_N];
	logic [srdz_pkg::LANES-1:0][srdz_pkg::Q_W-1:0]    dv_num  [0:DV_N];
	logic [srdz_pkg::LANES-1:0][srdz_pkg::Q_W-1:0]    dv_quo  [0:DV_N];
	srdz_pkg::div_side_t                              dv_side [0:DV_N];

	assign dv_vld[0]  = vld_s3;
	assign dv_rem[0]  = rem_s3;
	assign dv_den[0]  = den_s3;
	assign dv_num[0]  = num_s3;
	assign dv_quo[0]  = '0;
	assign dv_side[0] = side_s3;

	for (genvar i = 0; i < DV_N; i++) begin : g_div
		srdz_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (dv_vld[i]),
			.rem_i  (dv_rem[i]),
			.den_i  (dv_den[i]),
			.num_i  (dv_num[i]),
			.quo_i  (dv_quo[i]),
			.side_i (dv_side[i]),
			.vld_q  (dv_vld[i+1]),
			.rem_q  (dv_rem[i+1]),
			.den_q  (dv_den[i+1]),
			.num_q  (dv_num[i+1]),
			.quo_q  (dv_quo[i+1]),
			.side_q (dv_side[i+1])
		);
	end

	// saturate, sign and gate
	logic [15:0] qx, qy, ql, dx, dy, lv;
	srdz_pkg::div_side_t fs;

	assign qx = dv_quo[DV_N][0];
	assign qy = dv_quo[DV_N][1];
	assign ql = dv_quo[DV_N][2];
	assign fs = dv_side[DV_N];

	always_comb begin
		if (fs.x_neg) begin
			dx = 16'(-((qx > 16'd32768) ? 16'd32768 : qx));
		end else begin
			dx = (qx > 16'd32767) ? 16'd32767 : qx;
		end
		if (fs.y_neg) begin
			dy = 16'(-((qy > 16'd32768) ? 16'd32768 : qy));
		end else begin
			dy = (qy > 16'd32767) ? 16'd32767 : qy;
		end
		lv = (ql > 16'd32768) ? 16'd32768 : ql;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= dv_vld[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= fs.act ? {7'h00, 1'b1, lv, dy, dx} : '0;
		end
	end
endmodule

@@ hw/rtl/srdz_sqrt_cell.sv @@
// One root bit per cell of the magnitude square root chain
module srdz_sqrt_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  vld_i,
	input  logic [srdz_pkg::SREM_W-1:0]           rem_i,
	input  logic [srdz_pkg::ROOT_W-1:0]           root_i,
	input  logic [srdz_pkg::RAD_W-1:0]            rad_i,
	input  srdz_pkg::sqrt_side_t                  side_i,
	output logic                                  vld_q,
	output logic [srdz_pkg::SREM_W-1:0]           rem_q,
	output logic [srdz_pkg::ROOT_W-1:0]           root_q,
	output logic [srdz_pkg::RAD_W-1:0]            rad_q,
	output srdz_pkg::sqrt_side_t                  side_q
);
	logic [srdz_pkg::SREM_W-1:0] rem_n;
	logic [srdz_pkg::SREM_W-1:0] trial;
	logic                        take;

	always_comb begin
		rem_n = {rem_i[srdz_pkg::SREM_W-3:0], rad_i[srdz_pkg::RAD_W-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		take  = rem_n >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? rem_n - trial : rem_n;
			root_q <= {root_i[srdz_pkg::ROOT_W-2:0], take};
			rad_q  <= {rad_i[srdz_pkg::RAD_W-3:0], 2'b00};
			side_q <= side_i;
		end
	end
endmodule

@@ hw/rtl/srdz_div_cell.sv @@
// One quotient bit per cell for the three division lanes
module srdz_div_cell (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 en,
	input  logic                                                 vld_i,
	input  logic [srdz_pkg::LANES-1:0][srdz_pkg::DREM_W-1:0]     rem_i,
	input  logic [srdz_pkg::LANES-1:0][srdz_pkg::DEN_W-1:0]      den_i,
	input  logic [srdz_pkg::LANES-1:0][srdz_pkg::Q_W-1:0]        num_i,
	input  logic [srdz_pkg::LANES-1:0][srdz_pkg::Q_W-1:0]        quo_i,
	input  srdz_pkg::div_side_t                                  side_i,
	output logic                                                 vld_q,
	output logic [srdz_pkg::LANES-1:0][srdz_pkg::DREM_W-1:0]     rem_q,
	output logic [srdz_pkg::LANES-1:0][srdz_pkg::DEN_W-1:0]      den_q,
	output logic [srdz_pkg::LANES-1:0][srdz_pkg::Q_W-1:0]        num_q,
	output logic [srdz_pkg::LANES-1:0][srdz_pkg::Q_W-1:0]        quo_q,
	output srdz_pkg::div_side_t                                  side_q
);
	logic [srdz_pkg::LANES-1:0][srdz_pkg::DREM_W-1:0] rem_n;
	logic [srdz_pkg::LANES-1:0]                       take;

	always_comb begin
		for (int l = 0; l < srdz_pkg::LANES; l++) begin
			rem_n[l] = {rem_i[l][srdz_pkg::DREM_W-2:0], num_i[l][srdz_pkg::Q_W-1]};
			take[l]  = rem_n[l] >= {1'b0, den_i[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < srdz_pkg::LANES; l++) begin
				rem_q[l] <= take[l] ? rem_n[l] - {1'b0, den_i[l]} : rem_n[l];
				quo_q[l] <= {quo_i[l][srdz_pkg::Q_W-2:0], take[l]};
				num_q[l] <= {num_i[l][srdz_pkg::Q_W-2:0], 1'b0};
			end
			den_q  <= den_i;
			side_q <= side_i;
		end
	end
endmodule

@@ hw/rtl/srdz_checker.sv @@
// Port checks for the stick conditioner, bound to the top level
`include "stick_radial_dead_zone_macros.svh"

module srdz_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	`SRDZ_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`SRDZ_ASSERT_ALWAYS(a_ready_flow, clk, arst_n, s_tready == (!m_tvalid || m_tready), "input side not following output side")
	`SRDZ_ASSERT_ALWAYS(a_dead_zero, clk, arst_n, !m_tvalid || m_tdata[48] || (m_tdata[47:0] == 48'h0), "nonzero result inside dead zone")
	`SRDZ_ASSERT_ALWAYS(a_level_max, clk, arst_n, !m_tvalid || (m_tdata[47:32] <= 16'd32768), "level above full scale")
	`SRDZ_ASSERT_ALWAYS(a_fill_zero, clk, arst_n, !m_tvalid || (m_tdata[55:49] == 7'h00), "fill bits set")
endmodule

bind stick_radial_dead_zone srdz_checker u_srdz_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
